### hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the PWM duty-cycle capture block.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int COUNT_BITS         = 25;
    localparam int DUTY_FRACTION_BITS = 16;
    localparam int DUTY_BITS          = DUTY_FRACTION_BITS + 1;
    localparam int CFG_BITS           = 24;
    localparam int STEP_BITS          = $clog2(DUTY_FRACTION_BITS + 1);

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 24'd100000;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [COUNT_BITS:0]   t_rem;
    typedef logic [DUTY_BITS-1:0]  t_duty;
    typedef logic [CFG_BITS-1:0]   t_cfg;
    typedef logic [STEP_BITS-1:0]  t_step;

    typedef enum logic [1:0] {
        ST_MEASURED = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_WAIT_RISE = 3'd2,
        PH_WAIT_FALL = 3'd3,
        PH_WAIT_NEXT = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        DV_IDLE  = 3'd0,
        DV_DIFF  = 3'd1,
        DV_CHECK = 3'd2,
        DV_STEP  = 3'd3,
        DV_DONE  = 3'd4
    } t_div_state;

    typedef struct packed {
        logic start_req;
        logic pin_level;
    } t_in;

    typedef struct packed {
        t_status status;
        t_duty   duty_q16;
        t_count  high_ticks;
        t_count  period_ticks;
    } t_out;

    // edge stamps handed from the edge timer to the divider
    typedef struct packed {
        logic   valid;
        logic   timeout;
        t_count rise_time;
        t_count fall_time;
        t_count stop_time;
    } t_meas;

endpackage

### hdl/pdc_timer.sv
// ----------------------------------------------------------------------------
// pdc_timer
// Edge sequencer: tracks the measurement phase, counts elapsed ticks and
// stamps the rising and falling edges of the sampled line.
// ----------------------------------------------------------------------------
module pdc_timer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  pdc_pkg::t_in   i_in,
    input  pdc_pkg::t_cfg  i_timeout,
    output pdc_pkg::t_meas o_meas
);

    pdc_pkg::t_phase r_phase, n_phase;
    pdc_pkg::t_count r_elapsed, n_elapsed;
    pdc_pkg::t_count r_rise, n_rise;
    pdc_pkg::t_count r_fall, n_fall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pdc_pkg::PH_IDLE;
            r_elapsed <= '0;
            r_rise    <= '0;
            r_fall    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_rise    <= n_rise;
            r_fall    <= n_fall;
        end
    end

    always_comb begin
        logic            want;
        logic            active;
        logic            match;
        logic            late;
        pdc_pkg::t_count elapsed_inc;

        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_rise    = r_rise;
        n_fall    = r_fall;
        o_meas    = '0;
        want      = 1'b0;
        active    = 1'b1;

        unique case (r_phase)
            pdc_pkg::PH_WAIT_LOW:  want = 1'b0;
            pdc_pkg::PH_WAIT_RISE: want = 1'b1;
            pdc_pkg::PH_WAIT_FALL: want = 1'b0;
            pdc_pkg::PH_WAIT_NEXT: want = 1'b1;
            default:               active = 1'b0;
        endcase

        // elapsed saturates at all ones
        elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + pdc_pkg::t_count'(1);
        match       = (i_in.pin_level == want);
        late        = (elapsed_inc > pdc_pkg::t_count'(i_timeout));

        if (i_accept) begin
            if (i_in.start_req) begin
                n_elapsed = '0;
                n_rise    = '0;
                n_fall    = '0;
                n_phase   = i_in.pin_level ? pdc_pkg::PH_WAIT_LOW : pdc_pkg::PH_WAIT_RISE;
            end else if (!active) begin
                n_phase = pdc_pkg::PH_IDLE;
            end else begin
                n_elapsed = elapsed_inc;
                if (match) begin
                    unique case (r_phase)
                        pdc_pkg::PH_WAIT_LOW: begin
                            n_phase = pdc_pkg::PH_WAIT_RISE;
                        end
                        pdc_pkg::PH_WAIT_RISE: begin
                            n_rise  = elapsed_inc;
                            n_phase = pdc_pkg::PH_WAIT_FALL;
                        end
                        pdc_pkg::PH_WAIT_FALL: begin
                            n_fall  = elapsed_inc;
                            n_phase = pdc_pkg::PH_WAIT_NEXT;
                        end
                        default: begin
                            o_meas.valid     = 1'b1;
                            o_meas.rise_time = r_rise;
                            o_meas.fall_time = r_fall;
                            o_meas.stop_time = elapsed_inc;
                            n_phase          = pdc_pkg::PH_IDLE;
                        end
                    endcase
                end else if (late) begin
                    o_meas.valid   = 1'b1;
                    o_meas.timeout = 1'b1;
                    n_phase        = pdc_pkg::PH_IDLE;
                end
            end
        end
    end

endmodule

### hdl/pdc_div.sv
// ----------------------------------------------------------------------------
// pdc_div
// Result unit: forms high and period from the stamps, checks them and runs a
// bit-serial restoring divide for the duty, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pdc_pkg::t_meas i_meas,
    input  logic           i_take,
    output logic           o_busy,
    output logic           o_res_valid,
    output pdc_pkg::t_out  o_res
);

    pdc_pkg::t_div_state r_state, n_state;

    pdc_pkg::t_count  r_rise, r_fall, r_stop;
    pdc_pkg::t_count  r_hi, r_per;
    logic             r_bad;
    pdc_pkg::t_rem    r_rem;
    pdc_pkg::t_duty   r_quo;
    pdc_pkg::t_step   r_cnt;
    pdc_pkg::t_status r_status;

    pdc_pkg::t_rem shifted;
    pdc_pkg::t_rem per_ext;
    logic          ge;
    logic          check_bad;

    always_comb begin
        per_ext   = {1'b0, r_per};
        // first step takes the high count as it is, later steps shift in a zero
        shifted   = (r_cnt == '0) ? r_rem : {r_rem[pdc_pkg::COUNT_BITS-1:0], 1'b0};
        ge        = (shifted >= per_ext);
        check_bad = r_bad || (r_per == '0) || (r_hi > r_per);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdc_pkg::DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_busy      = 1'b1;
        o_res_valid = 1'b0;
        unique case (r_state)
            pdc_pkg::DV_IDLE: begin
                o_busy = 1'b0;
                if (i_meas.valid) begin
                    n_state = i_meas.timeout ? pdc_pkg::DV_DONE : pdc_pkg::DV_DIFF;
                end
            end
            pdc_pkg::DV_DIFF: begin
                n_state = pdc_pkg::DV_CHECK;
            end
            pdc_pkg::DV_CHECK: begin
                n_state = check_bad ? pdc_pkg::DV_DONE : pdc_pkg::DV_STEP;
            end
            pdc_pkg::DV_STEP: begin
                if (r_cnt == pdc_pkg::t_step'(pdc_pkg::DUTY_FRACTION_BITS)) begin
                    n_state = pdc_pkg::DV_DONE;
                end
            end
            pdc_pkg::DV_DONE: begin
                o_res_valid = 1'b1;
                if (i_take) begin
                    n_state = pdc_pkg::DV_IDLE;
                end
            end
            default: begin
                n_state = pdc_pkg::DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pdc_pkg::DV_IDLE: begin
                r_rise <= i_meas.rise_time;
                r_fall <= i_meas.fall_time;
                r_stop <= i_meas.stop_time;
                if (i_meas.valid && i_meas.timeout) begin
                    r_status <= pdc_pkg::ST_TIMEOUT;
                    r_hi     <= '0;
                    r_per    <= '0;
                    r_quo    <= '0;
                end
            end
            pdc_pkg::DV_DIFF: begin
                r_hi  <= r_fall - r_rise;
                r_per <= r_stop - r_rise;
                r_bad <= (r_fall < r_rise) || (r_stop < r_rise);
            end
            pdc_pkg::DV_CHECK: begin
                r_quo <= '0;
                r_rem <= {1'b0, r_hi};
                r_cnt <= '0;
                r_status <= check_bad ? pdc_pkg::ST_INVALID : pdc_pkg::ST_MEASURED;
            end
            pdc_pkg::DV_STEP: begin
                r_rem <= ge ? (shifted - per_ext) : shifted;
                r_quo <= {r_quo[pdc_pkg::DUTY_BITS-2:0], ge};
                r_cnt <= r_cnt + pdc_pkg::t_step'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_res.status       = r_status;
    assign o_res.duty_q16     = r_quo;
    assign o_res.high_ticks   = r_hi;
    assign o_res.period_ticks = r_per;

endmodule

### hdl/pwm_duty_cycle_capture_top.sv
// ----------------------------------------------------------------------------
// pwm_duty_cycle_capture_top
// Measures high time, period and duty of a sampled PWM line.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall   | start_req, pin_level
//  out     | output    | o_out_valid/i_out_stall | status, duty_q16, high/period
//  cfg     | input     | i_cfg_valid/o_cfg_ready | timeout_ticks (24 bits)
//
//  one sample request per cycle while a measurement is in progress
//  after the closing rising edge the input stalls while the divider forms the
//  difference, checks it, runs the serial divide and hands the result to the
//  output register, waiting while that register is full and stalled (timeout: hand-off only)
//  the output register frees the divider, so sampling resumes while a result waits
//  synchronous active-low reset: idle phase, timeout 100000, no result pending
// ----------------------------------------------------------------------------
module pwm_duty_cycle_capture_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pdc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pdc_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  pdc_pkg::t_cfg i_cfg_data
);

    pdc_pkg::t_cfg  r_timeout;
    logic           r_out_valid;
    pdc_pkg::t_out  r_out;

    logic           in_accept;
    logic           div_busy;
    logic           res_valid;
    logic           res_take;
    pdc_pkg::t_out  res;
    pdc_pkg::t_meas meas;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = div_busy;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign res_take    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= pdc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    pdc_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_in      (i_in_data),
        .i_timeout (r_timeout),
        .o_meas    (meas)
    );

    pdc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_meas      (meas),
        .i_take      (res_take),
        .o_busy      (div_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stamps only leave the timer on an accepted sample
    a_meas_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meas.valid |-> in_accept)
        else $error("edge event without an accepted sample");

    // the divider never gets a new event while busy
    a_no_event_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !meas.valid)
        else $error("edge event while result unit busy");

    // a measured result keeps the duty in range and high within period
    a_measured_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == pdc_pkg::ST_MEASURED) |->
        (o_out_data.duty_q16 <= pdc_pkg::t_duty'(1 << pdc_pkg::DUTY_FRACTION_BITS)
         && o_out_data.high_ticks <= o_out_data.period_ticks
         && o_out_data.period_ticks != '0))
        else $error("measured result out of range");

    // a timeout carries no counts
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == pdc_pkg::ST_TIMEOUT) |->
        (o_out_data.duty_q16 == '0 && o_out_data.high_ticks == '0
         && o_out_data.period_ticks == '0))
        else $error("timeout result with nonzero fields");

endmodule
